[hdl/assert_macros.svh]
// Assertion shorthands for the line clipper RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define LCV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define LCV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[hdl/lcv_pkg.sv]
// Shared types, codes and constants of the line clipper.
// No dependencies.
`timescale 1ns / 1ps
package lcv_pkg;

  localparam int CoordW  = 24;
  localparam int DiffW   = CoordW + 1;
  localparam int ProdW   = 2 * DiffW;
  localparam int MagW    = 2 * CoordW;
  localparam int QuoW    = MagW + 1;
  localparam int DenMagW = CoordW;
  localparam int CfgIdxW = 8;
  localparam int ClipPasses = 12;
  localparam int PassW   = $clog2(ClipPasses + 1);
  localparam int CntW    = $clog2(MagW);

  localparam logic [3:0] CodeLeft   = 4'd1;
  localparam logic [3:0] CodeRight  = 4'd2;
  localparam logic [3:0] CodeBottom = 4'd4;
  localparam logic [3:0] CodeTop    = 4'd8;

  typedef logic signed [CoordW-1:0] coord_t;

  localparam coord_t CoordMax = 24'sh7FFFFF;
  localparam coord_t CoordMin = -24'sh800000;

  localparam coord_t WinLeftRst   = 24'sd12800;
  localparam coord_t WinBottomRst = 24'sd12800;
  localparam coord_t WinRightRst  = 24'sd25600;
  localparam coord_t WinTopRst    = 24'sd25600;
  localparam coord_t ViewLeftRst  = 24'sd51200;
  localparam coord_t ViewBottomRst = 24'sd51200;
  localparam coord_t ViewRightRst = 24'sd76800;
  localparam coord_t ViewTopRst   = 24'sd76800;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_item_t;

  typedef struct packed {
    logic   accepted;
    coord_t view_start_x;
    coord_t view_start_y;
    coord_t view_end_x;
    coord_t view_end_y;
  } out_item_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIN_LEFT    = 8'd0,
    CFG_WIN_BOTTOM  = 8'd1,
    CFG_WIN_RIGHT   = 8'd2,
    CFG_WIN_TOP     = 8'd3,
    CFG_VIEW_LEFT   = 8'd4,
    CFG_VIEW_BOTTOM = 8'd5,
    CFG_VIEW_RIGHT  = 8'd6,
    CFG_VIEW_TOP    = 8'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_TOP,
    OP_BOTTOM,
    OP_RIGHT,
    OP_LEFT,
    OP_MAP
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_MUL,
    ST_DSTART,
    ST_DWAIT,
    ST_WRITE,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic       load;
    logic       op_mul;
    logic       div_start;
    logic       clip_wr;
    logic       map_wr;
    logic       out_load;
    logic       accept;
    op_e        op;
    logic       sel_end;
    logic [1:0] map_idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [3:0] code0;
    logic [3:0] code1;
    logic       div_done;
    logic       out_free;
  } ctrl_stat_t;

endpackage

[hdl/line_clip_to_viewport_top.sv]
// Line clipper top level: sequencer, datapath and output register.
// Depends on lcv_pkg, lcv_ctrl, lcv_dp and assert_macros.svh.
`timescale 1ns / 1ps
// Cohen-Sutherland clipper with window-to-viewport mapping. One segment is
// worked on at a time. Every clip pass and every one of the four mapping steps
// runs one multiply and one serial division through the single shared divider:
// a clip pass is outcode test, multiply, divider start, divider wait and write
// back, and a mapping step is the same without the outcode test. A segment
// gets at most 12 clip passes; an accepted one then runs the mapping steps, and
// its result may wait for the output register. The output register lets the
// next segment be taken while a result still waits. Config writes are taken
// every cycle (cfg_ready_o is tied high) and must only happen while the block
// is idle.
module line_clip_to_viewport_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  lcv_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output lcv_pkg::out_item_t           out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lcv_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  lcv_pkg::coord_t              cfg_data_i
);
  import lcv_pkg::*;
  `include "assert_macros.svh"

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;
  out_item_t  result, out_data_q;
  logic       out_valid_q;

  assign cfg_ready_o = 1'b1;

  lcv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lcv_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .cfg_wr_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .code0_o     (stat.code0),
    .code1_o     (stat.code1),
    .div_done_o  (stat.div_done),
    .result_o    (result)
  );

  // result slot frees up in the same cycle its beat is taken
  assign stat.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) out_data_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `LCV_ASSERT(a_no_load_after_accept, (in_valid_i && in_ready_o) |=> !cmd.out_load, "result loaded right after input beat")
  `LCV_ASSERT(a_reject_zero, (out_valid_o && !out_data_o.accepted) |-> (out_data_o.view_start_x == 0 && out_data_o.view_start_y == 0 && out_data_o.view_end_x == 0 && out_data_o.view_end_y == 0), "rejected beat carries nonzero coordinates")
  `LCV_ASSERT(a_no_overwrite, cmd.out_load |-> (!out_valid_q || out_ready_i), "result overwrote a pending beat")

endmodule

[hdl/lcv_div.sv]
// Serial signed divider, one quotient bit per cycle, truncates toward zero.
// Depends on lcv_pkg.
`timescale 1ns / 1ps
module lcv_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [lcv_pkg::ProdW-1:0]   num_i,
  input  logic signed [lcv_pkg::DiffW-1:0]   den_i,
  output logic                               done_o,
  output logic signed [lcv_pkg::QuoW-1:0]    quo_o
);
  import lcv_pkg::*;

  logic                busy_q, done_q;
  logic [CntW-1:0]     cnt_q;
  logic [DenMagW-1:0]  rem_q, den_q;
  logic [MagW-1:0]     quo_q;
  logic                neg_q;

  logic signed [ProdW-1:0] num_abs;
  logic signed [DiffW-1:0] den_abs;
  logic [DenMagW:0]        rem_sh, rem_sub;
  logic                    ge;
  logic signed [QuoW-1:0]  qm;

  always_comb begin
    num_abs = num_i[ProdW-1] ? -num_i : num_i;
    den_abs = den_i[DiffW-1] ? -den_i : den_i;
    rem_sh  = {rem_q, quo_q[MagW-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    ge      = rem_sh >= {1'b0, den_q};
    qm      = $signed({1'b0, quo_q});
    quo_o   = neg_q ? -qm : qm;
  end

  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(MagW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_abs[MagW-1:0];
      den_q <= den_abs[DenMagW-1:0];
      rem_q <= '0;
      neg_q <= num_i[ProdW-1] ^ den_i[DiffW-1];
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[DenMagW-1:0] : rem_sh[DenMagW-1:0];
      quo_q <= {quo_q[MagW-2:0], ge};
    end
  end

endmodule

[hdl/lcv_dp.sv]
// Clipper datapath: config registers, endpoints, outcodes, multiplier,
// shared divider and mapped results. Depends on lcv_pkg and lcv_div.
`timescale 1ns / 1ps
module lcv_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lcv_pkg::ctrl_cmd_t            cmd_i,
  input  lcv_pkg::in_item_t             in_data_i,
  input  logic                          cfg_wr_i,
  input  logic [lcv_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  lcv_pkg::coord_t               cfg_data_i,
  output logic [3:0]                    code0_o,
  output logic [3:0]                    code1_o,
  output logic                          div_done_o,
  output lcv_pkg::out_item_t            result_o
);
  import lcv_pkg::*;

  coord_t win_left_q, win_bottom_q, win_right_q, win_top_q;
  coord_t view_left_q, view_bottom_q, view_right_q, view_top_q;
  coord_t x0_q, y0_q, x1_q, y1_q;
  coord_t res_q [4];

  logic signed [ProdW-1:0] prod_q;
  logic signed [DiffW-1:0] den_q;
  coord_t                  base_q, edge_q;
  logic                    zero_q;

  logic signed [DiffW-1:0] opa, opb, opd;
  coord_t                  base, edge_pos, cv, wmin, wmax, vmin, vmax;
  logic signed [QuoW-1:0]  quo;
  logic signed [ProdW-1:0] wide;
  coord_t                  mapped, moved;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_left_q    <= WinLeftRst;
      win_bottom_q  <= WinBottomRst;
      win_right_q   <= WinRightRst;
      win_top_q     <= WinTopRst;
      view_left_q   <= ViewLeftRst;
      view_bottom_q <= ViewBottomRst;
      view_right_q  <= ViewRightRst;
      view_top_q    <= ViewTopRst;
    end else if (cfg_wr_i) begin
      unique case (cfg_index_i)
        CFG_WIN_LEFT:    win_left_q    <= cfg_data_i;
        CFG_WIN_BOTTOM:  win_bottom_q  <= cfg_data_i;
        CFG_WIN_RIGHT:   win_right_q   <= cfg_data_i;
        CFG_WIN_TOP:     win_top_q     <= cfg_data_i;
        CFG_VIEW_LEFT:   view_left_q   <= cfg_data_i;
        CFG_VIEW_BOTTOM: view_bottom_q <= cfg_data_i;
        CFG_VIEW_RIGHT:  view_right_q  <= cfg_data_i;
        CFG_VIEW_TOP:    view_top_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // outcodes, each bit on its own
  always_comb begin
    code0_o = '0;
    if (y0_q > win_top_q)    code0_o = code0_o | CodeTop;
    if (y0_q < win_bottom_q) code0_o = code0_o | CodeBottom;
    if (x0_q > win_right_q)  code0_o = code0_o | CodeRight;
    if (x0_q < win_left_q)   code0_o = code0_o | CodeLeft;
    code1_o = '0;
    if (y1_q > win_top_q)    code1_o = code1_o | CodeTop;
    if (y1_q < win_bottom_q) code1_o = code1_o | CodeBottom;
    if (x1_q > win_right_q)  code1_o = code1_o | CodeRight;
    if (x1_q < win_left_q)   code1_o = code1_o | CodeLeft;
  end

  // operand select
  always_comb begin
    wmin = cmd_i.map_idx[0] ? win_bottom_q  : win_left_q;
    wmax = cmd_i.map_idx[0] ? win_top_q     : win_right_q;
    vmin = cmd_i.map_idx[0] ? view_bottom_q : view_left_q;
    vmax = cmd_i.map_idx[0] ? view_top_q    : view_right_q;
    case (cmd_i.map_idx)
      2'd0:    cv = x0_q;
      2'd1:    cv = y0_q;
      2'd2:    cv = x1_q;
      default: cv = y1_q;
    endcase
    opa = '0; opb = '0; opd = '0; base = '0; edge_pos = '0;
    case (cmd_i.op)
      OP_TOP, OP_BOTTOM: begin
        edge_pos = (cmd_i.op == OP_TOP) ? win_top_q : win_bottom_q;
        opa  = DiffW'(x1_q) - DiffW'(x0_q);
        opb  = DiffW'(edge_pos) - DiffW'(y0_q);
        opd  = DiffW'(y1_q) - DiffW'(y0_q);
        base = x0_q;
      end
      OP_RIGHT, OP_LEFT: begin
        edge_pos = (cmd_i.op == OP_RIGHT) ? win_right_q : win_left_q;
        opa  = DiffW'(y1_q) - DiffW'(y0_q);
        opb  = DiffW'(edge_pos) - DiffW'(x0_q);
        opd  = DiffW'(x1_q) - DiffW'(x0_q);
        base = y0_q;
      end
      OP_MAP: begin
        opa  = DiffW'(cv) - DiffW'(wmin);
        opb  = DiffW'(vmax) - DiffW'(vmin);
        opd  = DiffW'(wmax) - DiffW'(wmin);
        base = vmin;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op_mul) begin
      prod_q <= opa * opb;
      den_q  <= opd;
      base_q <= base;
      edge_q <= edge_pos;
      zero_q <= (opd == '0);
    end
  end

  lcv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (prod_q),
    .den_i   (den_q),
    .done_o  (div_done_o),
    .quo_o   (quo)
  );

  // crossing point stays between the endpoints, so 24 bits suffice
  always_comb begin
    moved = base_q + coord_t'(quo);
    wide  = ProdW'(base_q) + (zero_q ? '0 : ProdW'(quo));
    if (wide > ProdW'(CoordMax))      mapped = CoordMax;
    else if (wide < ProdW'(CoordMin)) mapped = CoordMin;
    else                              mapped = coord_t'(wide);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x0_q <= in_data_i.start_x;
      y0_q <= in_data_i.start_y;
      x1_q <= in_data_i.end_x;
      y1_q <= in_data_i.end_y;
    end else if (cmd_i.clip_wr) begin
      if (cmd_i.op == OP_TOP || cmd_i.op == OP_BOTTOM) begin
        if (cmd_i.sel_end) begin
          x1_q <= moved; y1_q <= edge_q;
        end else begin
          x0_q <= moved; y0_q <= edge_q;
        end
      end else begin
        if (cmd_i.sel_end) begin
          y1_q <= moved; x1_q <= edge_q;
        end else begin
          y0_q <= moved; x0_q <= edge_q;
        end
      end
    end
    if (cmd_i.map_wr) begin
      res_q[cmd_i.map_idx] <= mapped;
    end
  end

  always_comb begin
    result_o.accepted     = cmd_i.accept;
    result_o.view_start_x = cmd_i.accept ? res_q[0] : '0;
    result_o.view_start_y = cmd_i.accept ? res_q[1] : '0;
    result_o.view_end_x   = cmd_i.accept ? res_q[2] : '0;
    result_o.view_end_y   = cmd_i.accept ? res_q[3] : '0;
  end

endmodule

[hdl/lcv_ctrl.sv]
// Clipper sequencer: outcode tests, clip passes, four mapping divisions.
// Depends on lcv_pkg.
`timescale 1ns / 1ps
module lcv_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lcv_pkg::ctrl_stat_t  stat_i,
  output lcv_pkg::ctrl_cmd_t   cmd_o
);
  import lcv_pkg::*;

  state_e           state_q, state_d;
  logic [PassW-1:0] pass_q, pass_d;
  op_e              op_q, op_d;
  logic             end_q, end_d, acc_q, acc_d;
  logic [1:0]       idx_q, idx_d;
  logic [3:0]       outc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pass_q  <= '0;
      op_q    <= OP_MAP;
      end_q   <= 1'b0;
      acc_q   <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      op_q    <= op_d;
      end_q   <= end_d;
      acc_q   <= acc_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    op_d    = op_q;
    end_d   = end_q;
    acc_d   = acc_q;
    idx_d   = idx_q;
    outc    = (stat_i.code0 != '0) ? stat_i.code0 : stat_i.code1;
    in_ready_o = 1'b0;
    cmd_o = '0;
    cmd_o.op      = op_q;
    cmd_o.sel_end = end_q;
    cmd_o.map_idx = idx_q;
    cmd_o.accept  = acc_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          pass_d  = '0;
          state_d = ST_TEST;
        end
      end
      ST_TEST: begin
        // pass budget used up: no further test, the segment is rejected
        if (pass_q == PassW'(ClipPasses) ||
            ((stat_i.code0 | stat_i.code1) != '0 &&
             (stat_i.code0 & stat_i.code1) != '0)) begin
          acc_d   = 1'b0;
          state_d = ST_FIN;
        end else if ((stat_i.code0 | stat_i.code1) == '0) begin
          acc_d   = 1'b1;
          op_d    = OP_MAP;
          idx_d   = '0;
          state_d = ST_MUL;
        end else begin
          end_d = (stat_i.code0 == '0);
          if ((outc & CodeTop) != '0)         op_d = OP_TOP;
          else if ((outc & CodeBottom) != '0) op_d = OP_BOTTOM;
          else if ((outc & CodeRight) != '0)  op_d = OP_RIGHT;
          else                                op_d = OP_LEFT;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.op_mul = 1'b1;
        state_d = ST_DSTART;
      end
      ST_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (stat_i.div_done) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        if (op_q == OP_MAP) begin
          cmd_o.map_wr = 1'b1;
          if (idx_q == 2'd3) begin
            state_d = ST_FIN;
          end else begin
            idx_d   = idx_q + 2'd1;
            state_d = ST_MUL;
          end
        end else begin
          cmd_o.clip_wr = 1'b1;
          pass_d  = pass_q + 1'b1;
          state_d = ST_TEST;
        end
      end
      ST_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[verif/line_clip_to_viewport_top_tb.sv]
// Testbench for the line clipper: directed and random segments against a scoreboard
// that clips and maps each segment itself. Depends on lcv_pkg and the clipper top.
`timescale 1ns / 1ps

// Scoreboard: holds its own copy of the window and viewport registers, works out
// the clipped, mapped segment for each accepted input beat, checks output beats.
class clip_scoreboard;
  longint wl, wb, wr, wt, vl, vb, vr, vt;
  lcv_pkg::out_item_t pending[$];
  int errors;

  function new();
    wl = 12800; wb = 12800; wr = 25600; wt = 25600;
    vl = 51200; vb = 51200; vr = 76800; vt = 76800;
    errors = 0;
  endfunction

  function void set_reg(logic [7:0] idx, lcv_pkg::coord_t val);
    longint v;
    v = longint'(val);
    case (idx)
      lcv_pkg::CFG_WIN_LEFT:    wl = v;
      lcv_pkg::CFG_WIN_BOTTOM:  wb = v;
      lcv_pkg::CFG_WIN_RIGHT:   wr = v;
      lcv_pkg::CFG_WIN_TOP:     wt = v;
      lcv_pkg::CFG_VIEW_LEFT:   vl = v;
      lcv_pkg::CFG_VIEW_BOTTOM: vb = v;
      lcv_pkg::CFG_VIEW_RIGHT:  vr = v;
      lcv_pkg::CFG_VIEW_TOP:    vt = v;
      default: ;
    endcase
  endfunction

  function logic [3:0] outcode(longint x, longint y);
    logic [3:0] c;
    c = '0;
    if (y > wt) c |= lcv_pkg::CodeTop;
    if (y < wb) c |= lcv_pkg::CodeBottom;
    if (x > wr) c |= lcv_pkg::CodeRight;
    if (x < wl) c |= lcv_pkg::CodeLeft;
    return c;
  endfunction

  function lcv_pkg::coord_t scale(longint c, longint lo, longint hi, longint vlo,
                                  longint vhi);
    longint v;
    v = vlo;
    if (hi != lo) v += ((c - lo) * (vhi - vlo)) / (hi - lo);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return lcv_pkg::coord_t'(v);
  endfunction

  function void note_segment(lcv_pkg::in_item_t s);
    longint x0, y0, x1, y1, nx, ny;
    logic [3:0] c0, c1, oc;
    bit ok;
    lcv_pkg::out_item_t r;
    x0 = longint'(s.start_x); y0 = longint'(s.start_y);
    x1 = longint'(s.end_x);   y1 = longint'(s.end_y);
    c0 = outcode(x0, y0); c1 = outcode(x1, y1);
    ok = 0;
    for (int p = 0; p < lcv_pkg::ClipPasses; p++) begin
      if ((c0 | c1) == 0) begin
        ok = 1;
        break;
      end
      if ((c0 & c1) != 0) break;
      oc = (c0 != 0) ? c0 : c1;
      if (oc & lcv_pkg::CodeTop) begin
        nx = x0 + ((x1 - x0) * (wt - y0)) / (y1 - y0); ny = wt;
      end else if (oc & lcv_pkg::CodeBottom) begin
        nx = x0 + ((x1 - x0) * (wb - y0)) / (y1 - y0); ny = wb;
      end else if (oc & lcv_pkg::CodeRight) begin
        ny = y0 + ((y1 - y0) * (wr - x0)) / (x1 - x0); nx = wr;
      end else begin
        ny = y0 + ((y1 - y0) * (wl - x0)) / (x1 - x0); nx = wl;
      end
      if (oc == c0) begin
        x0 = nx; y0 = ny; c0 = outcode(x0, y0);
      end else begin
        x1 = nx; y1 = ny; c1 = outcode(x1, y1);
      end
    end
    r = '0;
    if (ok) begin
      r.accepted = 1'b1;
      r.view_start_x = scale(x0, wl, wr, vl, vr);
      r.view_start_y = scale(y0, wb, wt, vb, vt);
      r.view_end_x   = scale(x1, wl, wr, vl, vr);
      r.view_end_y   = scale(y1, wb, wt, vb, vt);
    end
    pending.push_back(r);
  endfunction

  function void check_result(lcv_pkg::out_item_t got);
    lcv_pkg::out_item_t exp;
    if (pending.size() == 0) begin
      $error("output beat with no segment outstanding");
      errors++;
      return;
    end
    exp = pending.pop_front();
    if (got.accepted !== exp.accepted) begin
      $error("accepted: expected %0d, got %0d", exp.accepted, got.accepted);
      errors++;
    end
    if (got.view_start_x !== exp.view_start_x) begin
      $error("view_start_x: expected %0d, got %0d", exp.view_start_x, got.view_start_x);
      errors++;
    end
    if (got.view_start_y !== exp.view_start_y) begin
      $error("view_start_y: expected %0d, got %0d", exp.view_start_y, got.view_start_y);
      errors++;
    end
    if (got.view_end_x !== exp.view_end_x) begin
      $error("view_end_x: expected %0d, got %0d", exp.view_end_x, got.view_end_x);
      errors++;
    end
    if (got.view_end_y !== exp.view_end_y) begin
      $error("view_end_y: expected %0d, got %0d", exp.view_end_y, got.view_end_y);
      errors++;
    end
  endfunction
endclass

module line_clip_to_viewport_top_tb;
  import lcv_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  coord_t cfg_data_i = '0;

  clip_scoreboard board;
  // receiver modes: 0 random stall, 1 always ready; hold_req asks for a long hold-off
  int sink_mode = 0;
  bit hold_req = 0;

  line_clip_to_viewport_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Input and output beats are observed at the edge, after the scoreboard is built.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) board.note_segment(in_data_i);
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(out_data_o);
  end

  // Receiver: its own stall pattern, plus one long hold-off on request so the
  // output register and the engine both fill and in_ready_o drops.
  initial begin
    int ph;
    ph = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      ph++;
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (2000) @(posedge clk_i);
        hold_req = 0;
      end else if (sink_mode == 1) begin
        out_ready_i <= 1'b1;
      end else begin
        // bursts of readiness alternate with stall windows
        out_ready_i <= ((ph / 37) % 3 == 2) ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
    end
  end

  initial begin
    #400ms;
    $display("Some tests failed");
    $finish;
  end

  task automatic write_reg(cfg_idx_e idx, coord_t val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.set_reg(idx, val);
    cfg_valid_i <= 1'b0;
  endtask

  // Sends one segment; the beat is noted by the monitor process.
  task automatic send_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    in_valid_i <= 1'b1;
    in_data_i <= '{start_x: sx, start_y: sy, end_x: ex, end_y: ey};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic idle_sender(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Waits for every outstanding result, then lets the engine settle.
  task automatic drain();
    idle_sender(1);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic coord_t any_coord();
    return coord_t'($urandom());
  endfunction

  // Coordinate near the window span, occasionally far out or at the extremes.
  function automatic coord_t near(longint lo, longint hi);
    longint span, v;
    span = (hi > lo) ? hi - lo : lo - hi;
    if (span < 256) span = 256;
    case ($urandom_range(0, 9))
      0: return coord_t'($urandom());
      1: return CoordMax;
      2: return CoordMin;
      default: begin
        v = lo - span + longint'($urandom_range(0, 32'(3 * span)));
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return coord_t'(v);
      end
    endcase
  endfunction

  task automatic random_segments(int n);
    int burst;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 40));
      end
      burst--;
      if ($urandom_range(0, 9) == 0)
        send_segment(any_coord(), any_coord(), any_coord(), any_coord());
      else
        send_segment(near(board.wl, board.wr), near(board.wb, board.wt),
                     near(board.wl, board.wr), near(board.wb, board.wt));
    end
  endtask

  task automatic set_window(coord_t l, coord_t b, coord_t r, coord_t t,
                            coord_t vl, coord_t vb, coord_t vr, coord_t vt);
    write_reg(CFG_WIN_LEFT, l);
    write_reg(CFG_WIN_BOTTOM, b);
    write_reg(CFG_WIN_RIGHT, r);
    write_reg(CFG_WIN_TOP, t);
    write_reg(CFG_VIEW_LEFT, vl);
    write_reg(CFG_VIEW_BOTTOM, vb);
    write_reg(CFG_VIEW_RIGHT, vr);
    write_reg(CFG_VIEW_TOP, vt);
  endtask

  initial begin
    board = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset window 12800..25600, viewport 51200..76800.
    send_segment(24'sd19200, 24'sd19200, 24'sd20480, 24'sd23040); // inside
    send_segment(24'sd0, 24'sd0, 24'sd5000, 24'sd30000);           // share left
    send_segment(24'sd0, 24'sd19200, 24'sd40000, 24'sd19200);      // crosses L and R
    send_segment(24'sd19200, 24'sd0, 24'sd19200, 24'sd40000);      // crosses B and T
    send_segment(24'sd0, 24'sd0, 24'sd38400, 24'sd38400);          // diagonal corners
    send_segment(24'sd0, 24'sd24000, 24'sd16000, 24'sd40000);      // misses corner
    send_segment(CoordMin, CoordMin, CoordMax, CoordMax);           // extremes
    send_segment(CoordMax, CoordMin, CoordMin, CoordMax);
    send_segment(24'sd12800, 24'sd12800, 24'sd25600, 24'sd25600);  // on the edges
    send_segment(-24'sd1, 24'sd19200, 24'sd19200, -24'sd1);
    drain();

    // Extreme registers: viewport wide enough to saturate the mapping.
    set_window(-24'sd256, -24'sd256, 24'sd256, 24'sd256,
               CoordMin, CoordMin, CoordMax, CoordMax);
    send_segment(-24'sd1000, 24'sd10, 24'sd1000, -24'sd10);
    send_segment(24'sd255, 24'sd255, -24'sd255, -24'sd255);
    drain();
    set_window(-24'sd10, -24'sd10, 24'sd10, 24'sd10,
               CoordMax, CoordMax, CoordMin, CoordMin);          // flipped viewport
    send_segment(-24'sd100, 24'sd3, 24'sd100, 24'sd3);
    drain();
    // Zero-width and zero-height window.
    set_window(24'sd500, 24'sd700, 24'sd500, 24'sd700,
               24'sd0, 24'sd0, 24'sd4000, 24'sd4000);
    send_segment(24'sd500, 24'sd700, 24'sd500, 24'sd700);
    send_segment(24'sd0, 24'sd700, 24'sd1000, 24'sd700);
    drain();
    // Inverted window: points may carry opposite bits.
    set_window(24'sd5000, 24'sd5000, -24'sd5000, -24'sd5000,
               24'sd0, 24'sd0, 24'sd9000, 24'sd9000);
    send_segment(24'sd0, 24'sd0, 24'sd100, 24'sd50);
    send_segment(-24'sd6000, 24'sd6000, 24'sd6000, -24'sd6000);
    send_segment(CoordMin, CoordMax, CoordMax, CoordMin);
    drain();
    // Out-of-range register index is ignored by the block.
    cfg_valid_i <= 1'b1;
    cfg_index_i <= 8'(CFG_VIEW_TOP) + 8'd1;
    cfg_data_i <= CoordMax;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= 8'hFF;
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;

    // Random phases, each with its own window.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) begin
        set_window(any_coord(), any_coord(), any_coord(), any_coord(),
                   any_coord(), any_coord(), any_coord(), any_coord());
      end else begin
        automatic int l = $urandom_range(0, 40000) - 20000;
        automatic int b = $urandom_range(0, 40000) - 20000;
        set_window(coord_t'(l), coord_t'(b),
                   coord_t'(l + $urandom_range(1, 30000)),
                   coord_t'(b + $urandom_range(1, 30000)),
                   any_coord(), any_coord(), any_coord(), any_coord());
      end
      sink_mode = (ph == 2) ? 1 : 0;
      if (ph == 1) hold_req = 1;   // long receiver hold-off while we keep sending
      random_segments(150);
      if (ph == 3) drain();        // sender waits for every result, then resumes
      random_segments(8);
      drain();
    end
    in_valid_i <= 1'b0;
    sink_mode = 1;
    repeat (800) @(posedge clk_i);

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+hdl
hdl/lcv_pkg.sv
hdl/lcv_div.sv
hdl/lcv_dp.sv
hdl/lcv_ctrl.sv
hdl/line_clip_to_viewport_top.sv
verif/line_clip_to_viewport_top_tb.sv
